// ----- hdl/bda_pkg.sv -----
// ----------------------------------------------------------------------------
// bda_pkg
// shared types, widths and trig tables for the bisection direction angle block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bda_pkg;

    // bisection depth and coordinate format
    localparam int STEPS       = 10;
    localparam int COORD_WIDTH = 16;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int MAG_W       = COORD_WIDTH;

    // fine angle grid: a quarter circle is 2048 << FRAC_BITS
    localparam int FRAC_BITS = 4;
    localparam int FINE_W    = 15;
    localparam int QANG_W    = FINE_W - FRAC_BITS;
    localparam int ANG_W     = 13;

    localparam int QUARTER = 2048;
    localparam int HALF    = 4096;

    // q30 trig values, range 0 .. 2^30
    localparam int Q_W    = 31;
    localparam int PROD_W = MAG_W + Q_W;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam int          TAYLOR_TERMS = 9;

    localparam int unsigned SIN_DIV [1:TAYLOR_TERMS] =
        '{6, 20, 42, 72, 110, 156, 210, 272, 342};
    localparam int unsigned COS_DIV [1:TAYLOR_TERMS] =
        '{2, 12, 30, 56, 90, 132, 182, 240, 306};

    // input register, a multiply and a compare stage per step, output register
    localparam int N_STAGE = 2 * STEPS + 2;

    typedef struct packed {
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
        logic             dx_neg;
        logic             dy_neg;
        logic             dx_zero;
        logic             dy_zero;
    } geom_t;

    // decisions shift in at the lsb, the earliest one ends up highest
    typedef struct packed {
        geom_t            geom;
        logic [STEPS-1:0] path;
    } item_t;

    typedef struct packed {
        logic [Q_W-1:0] cos_q;
        logic [Q_W-1:0] sin_q;
    } trig_t;

    typedef struct packed {
        logic adv_m;
        logic adv_c;
    } step_ctl_t;

    typedef struct packed {
        logic m_valid;
        logic c_valid;
    } step_stat_t;

    // q30 sine or cosine of fine angle m by truncated taylor series
    function automatic logic [Q_W-1:0] trig_q30(input int unsigned m, input logic want_sin);
        logic [63:0] theta;
        logic [63:0] th2;
        logic [63:0] term;
        longint      sum;
        theta = (64'(m) * HALF_PI_Q30) >> 15;
        th2   = (theta * theta) >> 30;
        term  = want_sin ? theta : ONE_Q30;
        sum   = longint'(term);
        for (int k = 1; k <= TAYLOR_TERMS; k++) begin
            if (want_sin)
                term = ((term * th2) >> 30) / 64'(SIN_DIV[k]);
            else
                term = ((term * th2) >> 30) / 64'(COS_DIV[k]);
            if ((k % 2) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > longint'(ONE_Q30))
            sum = longint'(ONE_Q30);
        return Q_W'(sum);
    endfunction

    // midpoint tested at a given step for a given decision path
    function automatic int unsigned step_mid(input int unsigned step, input int unsigned node);
        return (2 * node + 1) << (FINE_W - 1 - step);
    endfunction

    function automatic trig_t trig_pair(input int unsigned step, input int unsigned node);
        trig_t t;
        t.cos_q = trig_q30(step_mid(step, node), 1'b0);
        t.sin_q = trig_q30(step_mid(step, node), 1'b1);
        return t;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/bisection_direction_angle.sv -----
// ----------------------------------------------------------------------------
// bisection_direction_angle
// clockwise direction angle between two points, units of 2*pi/8192
// ----------------------------------------------------------------------------
// A beat on the input channel carries a start point and a target point; the
// matching beat on the output channel carries the clockwise angle from the +x
// axis (screen y grows downward) to the vector between them, 0..8191. The
// block is a 22 stage pipeline: an input register that forms the differences
// and their magnitudes, then for each of the ten bisection steps a multiply
// stage and a compare stage, then an output register that folds the quadrant
// back in. It takes one beat per cycle unless every stage is full and the
// output is stalled. The two 16 x 31 bit multipliers of each step have a
// stage to themselves. Stalls ripple back only through full stages, so empty
// slots are closed up and the input keeps taking beats while a result waits.
// There is no memory and no start-up sweep. dx equal to zero gives a quarter
// or three-quarter circle (a quarter circle when both points coincide), dy
// equal to zero gives zero or a half circle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bisection_direction_angle (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic signed [bda_pkg::COORD_WIDTH-1:0] from_x,
    input  wire logic signed [bda_pkg::COORD_WIDTH-1:0] from_y,
    input  wire logic signed [bda_pkg::COORD_WIDTH-1:0] to_x,
    input  wire logic signed [bda_pkg::COORD_WIDTH-1:0] to_y,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [bda_pkg::ANG_W-1:0]               angle
);

    localparam int STEPS   = bda_pkg::STEPS;
    localparam int N_STAGE = bda_pkg::N_STAGE;

    // per stage valid and advance; a stage moves when it is empty or the
    // one after it moves
    logic [N_STAGE-1:0] v;
    logic [N_STAGE-1:0] adv;

    // input stage
    logic                               s0_valid_reg;
    bda_pkg::item_t                     s0_item_reg;
    bda_pkg::item_t                     s0_item_next;
    logic signed [bda_pkg::DIFF_W-1:0]  dx;
    logic signed [bda_pkg::DIFF_W-1:0]  dy;
    logic signed [bda_pkg::DIFF_W-1:0]  ndx;
    logic signed [bda_pkg::DIFF_W-1:0]  ndy;

    // step chain
    bda_pkg::step_ctl_t   ctl    [STEPS];
    bda_pkg::step_stat_t  stat   [STEPS];
    bda_pkg::item_t       m_item [STEPS];
    bda_pkg::item_t       c_item [STEPS];
    bda_pkg::trig_t       c_lo   [STEPS];
    bda_pkg::trig_t       c_hi   [STEPS];

    // output stage
    logic                             out_valid_reg;
    logic [bda_pkg::ANG_W-1:0]        angle_reg;
    logic [bda_pkg::ANG_W-1:0]        angle_next;
    logic [bda_pkg::FINE_W-1:0]       fine_mid;
    logic [bda_pkg::QANG_W-1:0]       qang;
    logic [bda_pkg::ANG_W-1:0]        q;
    bda_pkg::item_t                   last;

    // ------------------------------------------------------------------
    // flow control
    // ------------------------------------------------------------------
    assign v[0]         = s0_valid_reg;
    assign v[N_STAGE-1] = out_valid_reg;

    assign adv[N_STAGE-1] = !v[N_STAGE-1] || !out_stall;

    for (genvar i = 0; i < N_STAGE - 1; i++)
    begin : g_adv
        assign adv[i] = !v[i] || adv[i+1];
    end

    assign in_stall = !adv[0];

    // ------------------------------------------------------------------
    // input stage: differences, magnitudes and quadrant flags
    // ------------------------------------------------------------------
    always_comb
    begin
        dx  = {to_x[bda_pkg::COORD_WIDTH-1], to_x} - {from_x[bda_pkg::COORD_WIDTH-1], from_x};
        dy  = {to_y[bda_pkg::COORD_WIDTH-1], to_y} - {from_y[bda_pkg::COORD_WIDTH-1], from_y};
        ndx = -dx;
        ndy = -dy;
        s0_item_next.geom.dx_neg  = dx[bda_pkg::DIFF_W-1];
        s0_item_next.geom.dy_neg  = dy[bda_pkg::DIFF_W-1];
        s0_item_next.geom.dx_zero = (dx == '0);
        s0_item_next.geom.dy_zero = (dy == '0);
        s0_item_next.geom.ax = dx[bda_pkg::DIFF_W-1] ? ndx[bda_pkg::MAG_W-1:0]
                                                     : dx[bda_pkg::MAG_W-1:0];
        s0_item_next.geom.ay = dy[bda_pkg::DIFF_W-1] ? ndy[bda_pkg::MAG_W-1:0]
                                                     : dy[bda_pkg::MAG_W-1:0];
        s0_item_next.path = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (adv[0])
            s0_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
            s0_item_reg <= s0_item_next;
    end

    // ------------------------------------------------------------------
    // bisection steps; each compare stage but the last prefetches both
    // candidate sin/cos pairs for the next step from its constant tables
    // ------------------------------------------------------------------
    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic            up_valid;
        bda_pkg::item_t  up_item;
        bda_pkg::trig_t  up_lo;
        bda_pkg::trig_t  up_hi;
        bda_pkg::trig_t  pre_lo;
        bda_pkg::trig_t  pre_hi;

        assign ctl[k].adv_m = adv[2*k+1];
        assign ctl[k].adv_c = adv[2*k+2];
        assign v[2*k+1]     = stat[k].m_valid;
        assign v[2*k+2]     = stat[k].c_valid;

        if (k == 0)
        begin : g_first
            // first midpoint is fixed
            assign up_valid = s0_valid_reg;
            assign up_item  = s0_item_reg;
            assign up_lo    = bda_pkg::trig_pair(0, 0);
            assign up_hi    = bda_pkg::trig_pair(0, 0);
        end
        else
        begin : g_link
            assign up_valid = stat[k-1].c_valid;
            assign up_item  = c_item[k-1];
            assign up_lo    = c_lo[k-1];
            assign up_hi    = c_hi[k-1];
        end

        if (k == STEPS - 1)
        begin : g_no_pre
            // nothing follows the last step
            assign pre_lo = '0;
            assign pre_hi = '0;
        end
        else if (k == 0)
        begin : g_pre_const
            assign pre_lo = bda_pkg::trig_pair(1, 0);
            assign pre_hi = bda_pkg::trig_pair(1, 1);
        end
        else
        begin : g_pre_tab
            // halves of the next step's table, split by this step's decision
            bda_pkg::trig_t lo_tab [2**k];
            bda_pkg::trig_t hi_tab [2**k];

            for (genvar e = 0; e < 2**k; e++)
            begin : g_entry
                assign lo_tab[e] = bda_pkg::trig_pair(k + 1, 2 * e);
                assign hi_tab[e] = bda_pkg::trig_pair(k + 1, 2 * e + 1);
            end

            assign pre_lo = lo_tab[m_item[k].path[k-1:0]];
            assign pre_hi = hi_tab[m_item[k].path[k-1:0]];
        end

        bda_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl[k]),
            .up_valid (up_valid),
            .up_item  (up_item),
            .up_lo    (up_lo),
            .up_hi    (up_hi),
            .pre_lo   (pre_lo),
            .pre_hi   (pre_hi),
            .stat     (stat[k]),
            .m_item   (m_item[k]),
            .c_item   (c_item[k]),
            .c_lo     (c_lo[k]),
            .c_hi     (c_hi[k])
        );
    end

    // ------------------------------------------------------------------
    // output stage: final midpoint, special cases, quadrant fold
    // ------------------------------------------------------------------
    assign last = c_item[STEPS-1];

    always_comb
    begin
        // final interval is path-aligned, its midpoint adds half a cell
        fine_mid = bda_pkg::FINE_W'({last.path, 1'b1}) << (bda_pkg::FINE_W - 1 - STEPS);
        qang     = fine_mid[bda_pkg::FINE_W-1:bda_pkg::FRAC_BITS];

        // dx zero is tested before dy zero
        if (last.geom.dx_zero)
            q = bda_pkg::ANG_W'(bda_pkg::QUARTER);
        else if (last.geom.dy_zero)
            q = '0;
        else
            q = bda_pkg::ANG_W'(qang);

        // all sums wrap at a full circle
        if (last.geom.dy_neg && last.geom.dx_neg)
            angle_next = bda_pkg::ANG_W'(bda_pkg::HALF) + q;
        else if (last.geom.dy_neg)
            angle_next = '0 - q;
        else if (last.geom.dx_neg)
            angle_next = bda_pkg::ANG_W'(bda_pkg::HALF) - q;
        else
            angle_next = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv[N_STAGE-1])
            out_valid_reg <= stat[STEPS-1].c_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv[N_STAGE-1])
            angle_reg <= angle_next;
    end

    assign out_valid = out_valid_reg;
    assign angle     = angle_reg;

endmodule

`default_nettype wire

// ----- hdl/bda_step.sv -----
// ----------------------------------------------------------------------------
// bda_step
// one bisection step: multiply stage then compare stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bda_step (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bda_pkg::step_ctl_t  ctl,
    input  wire logic                up_valid,
    input  wire bda_pkg::item_t      up_item,
    input  wire bda_pkg::trig_t      up_lo,
    input  wire bda_pkg::trig_t      up_hi,
    input  wire bda_pkg::trig_t      pre_lo,
    input  wire bda_pkg::trig_t      pre_hi,
    output bda_pkg::step_stat_t      stat,
    output bda_pkg::item_t           m_item,
    output bda_pkg::item_t           c_item,
    output bda_pkg::trig_t           c_lo,
    output bda_pkg::trig_t           c_hi
);

    logic                         m_valid_reg;
    bda_pkg::item_t               m_item_reg;
    logic [bda_pkg::PROD_W-1:0]   pc_reg;
    logic [bda_pkg::PROD_W-1:0]   ps_reg;
    logic [bda_pkg::PROD_W-1:0]   pc_next;
    logic [bda_pkg::PROD_W-1:0]   ps_next;
    bda_pkg::trig_t               sel;

    logic                         c_valid_reg;
    bda_pkg::item_t               c_item_reg;
    bda_pkg::item_t               c_item_next;
    bda_pkg::trig_t               c_lo_reg;
    bda_pkg::trig_t               c_hi_reg;
    logic                         upper;

    // previous decision picks the prefetched candidate
    always_comb
    begin
        sel     = up_item.path[0] ? up_hi : up_lo;
        pc_next = bda_pkg::PROD_W'(up_item.geom.ay) * bda_pkg::PROD_W'(sel.cos_q);
        ps_next = bda_pkg::PROD_W'(up_item.geom.ax) * bda_pkg::PROD_W'(sel.sin_q);
    end

    // dy*cos < dx*sin keeps the lower half
    always_comb
    begin
        upper       = !(pc_reg < ps_reg);
        c_item_next = m_item_reg;
        c_item_next.path = {m_item_reg.path[bda_pkg::STEPS-2:0], upper};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.adv_m)
                m_valid_reg <= up_valid;
            if (ctl.adv_c)
                c_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv_m)
        begin
            m_item_reg <= up_item;
            pc_reg     <= pc_next;
            ps_reg     <= ps_next;
        end
        if (ctl.adv_c)
        begin
            c_item_reg <= c_item_next;
            c_lo_reg   <= pre_lo;
            c_hi_reg   <= pre_hi;
        end
    end

    assign stat.m_valid = m_valid_reg;
    assign stat.c_valid = c_valid_reg;
    assign m_item       = m_item_reg;
    assign c_item       = c_item_reg;
    assign c_lo         = c_lo_reg;
    assign c_hi         = c_hi_reg;

endmodule

`default_nettype wire

// ----- hdl/bda_checker.sv -----
// ----------------------------------------------------------------------------
// bda_checker
// port level checks for the bisection direction angle block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bda_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_stall,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic [bda_pkg::ANG_W-1:0]   angle
);

    // a held result beat stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(angle))
        else $error("output beat dropped or changed while stalled");

    // input only backs up when every stage is full and the output is held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with room in the pipeline");

    // a drained output lets the whole pipeline move
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |-> !in_stall)
        else $error("input stalled while output beat taken");

    // bisection answers are odd, special cases sit on quarter circles
    a_angle_grid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> angle[0] || (angle[10:0] == 11'd0))
        else $error("angle off the bisection grid");

    // while an input beat waits under stall, the output stays valid
    a_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> out_valid)
        else $error("pipeline emptied while input was stalled");

endmodule

bind bisection_direction_angle bda_checker u_bda_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .angle     (angle)
);

`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the bisection direction angle pipeline
// ----------------------------------------------------------------------------
// Point pairs go in through the valid/stall input channel. Each accepted beat
// is run through a local bit-accurate predictor: the q30 taylor sine/cosine
// table, ten bisection steps and the quadrant fold. The predicted angle is
// queued. A checking process pops the oldest angle for every beat taken on the
// output channel and compares it. In some tests the sender works in bursts
// with random gaps. The receiver stalls on a pattern that each test selects.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int CW = bda_pkg::COORD_WIDTH;
    localparam int AW = bda_pkg::ANG_W;

    // q30 fixed point for the trig table
    localparam bit [63:0] HALF_PI_FX = 64'd1686629713;
    localparam bit [63:0] ONE_FX     = 64'd1 << 30;
    localparam int        SERIES_LEN = 9;
    localparam int        FINE_SHIFT = 4;
    localparam int        BISECT_N   = 10;

    // drain wait after the queue empties: pipeline depth plus margin
    localparam int DRAIN_CYCLES = 40;
    // far beyond the slowest legal run
    localparam time RUN_LIMIT   = 2_000_000ns;

    typedef enum {SINK_OPEN, SINK_RANDOM, SINK_BURSTY} sink_mode_t;

    // one pending angle, with its points kept for the report
    typedef struct {
        logic signed [CW-1:0] fx;
        logic signed [CW-1:0] fy;
        logic signed [CW-1:0] tx;
        logic signed [CW-1:0] ty;
        bit [AW-1:0]          angle;
    } pending_angle_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic signed [CW-1:0] from_x    = '0;
    logic signed [CW-1:0] from_y    = '0;
    logic signed [CW-1:0] to_x      = '0;
    logic signed [CW-1:0] to_y      = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [AW-1:0]        angle;

    pending_angle_t pending_angles[$];
    int             n_sent    = 0;
    int             n_checked = 0;
    int             n_errors  = 0;

    // sender pacing and receiver stall pattern, set per test
    bit             src_gappy = 1'b0;
    int             burst_left = 0;
    sink_mode_t     sink_mode = SINK_OPEN;
    bit             sink_hold = 1'b0;
    int             sink_run  = 0;

    bisection_direction_angle u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .from_x    (from_x),
        .from_y    (from_y),
        .to_x      (to_x),
        .to_y      (to_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .angle     (angle)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // q30 sine or cosine of a fine grid angle, truncating taylor series
    function automatic bit [63:0] q30_trig(input int unsigned m, input bit want_sin);
        bit [63:0] theta;
        bit [63:0] theta_sq;
        bit [63:0] term;
        bit [63:0] div;
        longint    acc;
        int        k;
        theta    = (64'(m) * HALF_PI_FX) >> 15;
        theta_sq = (theta * theta) >> 30;
        term     = want_sin ? theta : ONE_FX;
        acc      = longint'(term);
        for (k = 1; k <= SERIES_LEN; k++)
        begin
            // factorial step: (2k)(2k+1) for sine, (2k-1)(2k) for cosine
            if (want_sin)
                div = 64'((2 * k) * (2 * k + 1));
            else
                div = 64'((2 * k - 1) * (2 * k));
            term = ((term * theta_sq) >> 30) / div;
            if (k % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        if (acc > longint'(ONE_FX))
            acc = longint'(ONE_FX);
        return 64'(acc);
    endfunction

    // first-quadrant angle: dy/dx < tan(mid) tested as dy*cos < dx*sin
    function automatic int unsigned quadrant_angle(input bit [63:0] ax, input bit [63:0] ay);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int          i;
        if (ax == 0)
            return bda_pkg::QUARTER;
        if (ay == 0)
            return 0;
        lo = 0;
        hi = bda_pkg::QUARTER << FINE_SHIFT;
        for (i = 0; i < BISECT_N; i++)
        begin
            mid = (lo + hi) >> 1;
            if (ay * q30_trig(mid, 1'b0) < ax * q30_trig(mid, 1'b1))
                hi = mid;
            else
                lo = mid;
        end
        mid = (lo + hi) >> 1;
        return mid >> FINE_SHIFT;
    endfunction

    // clockwise screen angle from one point to another, folded by quadrant
    function automatic bit [AW-1:0] direction_of(input logic signed [CW-1:0] fx,
                                                 input logic signed [CW-1:0] fy,
                                                 input logic signed [CW-1:0] tx,
                                                 input logic signed [CW-1:0] ty);
        longint      dx;
        longint      dy;
        int unsigned q;
        int unsigned a;
        dx = longint'(tx) - longint'(fx);
        dy = longint'(ty) - longint'(fy);
        q  = quadrant_angle(64'(dx < 0 ? -dx : dx), 64'(dy < 0 ? -dy : dy));
        if (dy < 0)
            a = (dx < 0) ? bda_pkg::HALF + q : 8192 - q;
        else
            a = (dx < 0) ? bda_pkg::HALF - q : q;
        return AW'(a);
    endfunction

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // one beat: called at a falling edge, returns at a falling edge with
    // in_valid still high so a following beat goes out back to back
    task automatic send_points(input logic signed [CW-1:0] fx, input logic signed [CW-1:0] fy,
                               input logic signed [CW-1:0] tx, input logic signed [CW-1:0] ty);
        pending_angle_t p;
        in_valid <= 1'b1;
        from_x   <= fx;
        from_y   <= fy;
        to_x     <= tx;
        to_y     <= ty;
        do
            @(posedge clk);
        while (in_stall);
        p.fx    = fx;
        p.fy    = fy;
        p.tx    = tx;
        p.ty    = ty;
        p.angle = direction_of(fx, fy, tx, ty);
        pending_angles.push_back(p);
        n_sent++;
        @(negedge clk);
    endtask

    // random start point such that start + d stays inside the coordinate range
    function automatic int pick_origin(input int d);
        int lo;
        int hi;
        lo = (d < 0) ? -32768 - d : -32768;
        hi = (d < 0) ? 32767 : 32767 - d;
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // burst bookkeeping, then one beat with the given displacement
    task automatic send_delta(input int d_x, input int d_y);
        int fx;
        int fy;
        int gap;
        if (src_gappy)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 7);
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        fx = pick_origin(d_x);
        fy = pick_origin(d_y);
        send_points(CW'(fx), CW'(fy), CW'(fx + d_x), CW'(fy + d_y));
    endtask

    // ------------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------------

    // receiver stall pattern: open, random, or alternating stalled and open runs
    always @(negedge clk)
    begin
        if (sink_run == 0)
        begin
            sink_hold = ~sink_hold;
            sink_run  = $urandom_range(1, 12);
        end
        sink_run--;
        case (sink_mode)
            SINK_RANDOM: out_stall <= ($urandom_range(0, 99) < 40);
            SINK_BURSTY: out_stall <= sink_hold;
            default:     out_stall <= 1'b0;
        endcase
    end

    // every beat taken on the output is held against the oldest prediction
    always @(posedge clk)
    begin
        pending_angle_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_angles.size() == 0)
            begin
                $display("%0t: unexpected angle, expected none, got %0d", $time, angle);
                n_errors++;
            end
            else
            begin
                want = pending_angles.pop_front();
                n_checked++;
                if (angle !== want.angle)
                begin
                    $display("%0t: angle mismatch, expected %0d, got %0d (%0d,%0d -> %0d,%0d)",
                             $time, want.angle, angle, want.fx, want.fy, want.tx, want.ty);
                    n_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // axes, coincident points, full-span extremes and the four quadrants
    task automatic test_special_cases();
        src_gappy = 1'b0;
        sink_mode = SINK_OPEN;
        send_points(0, 0, 0, 0);                          // same point
        send_points(100, -50, 100, -50);                  // same point, off origin
        send_points(5, 5, 5, 900);                        // straight down screen
        send_points(5, 5, 5, -900);                       // straight up screen
        send_points(-32768, 0, 32767, 0);                 // widest +x span
        send_points(32767, 0, -32768, 0);                 // widest -x span
        send_points(0, -32768, 0, 32767);
        send_points(0, 32767, 0, -32768);
        send_points(-32768, -32768, 32767, 32767);        // corner to corner
        send_points(32767, 32767, -32768, -32768);
        send_points(-32768, 32767, 32767, -32768);
        send_points(32767, -32768, -32768, 32767);
        send_points(-32768, 0, 32767, 1);                 // barely off the x axis
        send_points(0, -32768, 1, 32767);                 // barely off the y axis
        send_points(0, 0, 1, 1);                          // diagonals, each quadrant
        send_points(0, 0, -1, 1);
        send_points(0, 0, -1, -1);
        send_points(0, 0, 1, -1);
        send_points(0, 0, 3, 4);
        send_points(0, 0, -32768, -1);
        send_points(10, 20, -7, -13);
        send_points(-1, -1, -1, -1);
        sink_mode = SINK_RANDOM;
        send_points(-12345, 321, 23456, -30000);
        send_points(32767, 32767, 32767, 32767);
    endtask

    // unconstrained point pairs over the whole plane
    task automatic test_random_pairs(input int n);
        int i;
        src_gappy = 1'b1;
        sink_mode = SINK_RANDOM;
        for (i = 0; i < n; i++)
        begin
            if (i == n / 2)
                sink_mode = SINK_BURSTY;
            send_delta(int'($urandom_range(0, 131070)) - 65535,
                       int'($urandom_range(0, 131070)) - 65535);
        end
    endtask

    // short displacements, so zero and tiny components come up often
    task automatic test_short_vectors(input int n);
        int i;
        src_gappy = 1'b1;
        sink_mode = SINK_BURSTY;
        for (i = 0; i < n; i++)
            send_delta(int'($urandom_range(0, 16)) - 8, int'($urandom_range(0, 16)) - 8);
    endtask

    // long vectors hugging an axis or a diagonal, where decisions are tight
    task automatic test_near_boundaries(input int n);
        int i;
        int d;
        int wobble;
        src_gappy = 1'b0;
        sink_mode = SINK_OPEN;
        for (i = 0; i < n; i++)
        begin
            if (i == n / 3)
                sink_mode = SINK_RANDOM;
            if (i == 2 * n / 3)
                src_gappy = 1'b1;
            d      = int'($urandom_range(0, 60000)) - 30000;
            wobble = int'($urandom_range(0, 6)) - 3;
            case ($urandom_range(0, 3))
                0:       send_delta(d, wobble);
                1:       send_delta(wobble, d);
                2:       send_delta(d, d + wobble);
                default: send_delta(d, -d + wobble);
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_special_cases();
        test_random_pairs(300);
        test_short_vectors(150);
        test_near_boundaries(150);

        in_valid <= 1'b0;
        sink_mode = SINK_RANDOM;
        while (pending_angles.size() != 0)
            @(posedge clk);
        // let any stray beat show up before closing
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d angles checked from %0d point pairs: axes, coincident points,",
                 n_checked, n_sent);
        $display("full-span extremes, random, short and near-axis/diagonal vectors");
        if (n_errors == 0 && pending_angles.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog
    initial
    begin
        #(RUN_LIMIT);
        $display("timeout with %0d angles still pending", pending_angles.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
